FILE: sv/tdfp_pkg.sv
// Shared types, constants and the tag lookup for the tagged decimal field parser.
package tdfp_pkg;

    // Width of one value in thousandths and of the widened multiply-add result.
    localparam int VALUE_W    = 48;
    localparam int WIDE_W     = VALUE_W + 5;
    localparam int CHAR_W     = 8;
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = 2;

    typedef logic signed [VALUE_W-1:0]           t_value;
    typedef logic [SLOT_COUNT-1:0][VALUE_W-1:0]  t_value_arr;
    typedef logic [SLOT_W-1:0]                   t_slot;
    typedef logic [CHAR_W-1:0]                   t_char;

    // Saturation limits of the signed value range.
    localparam t_value VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam t_value VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Error value loaded at reset, in thousandths.
    localparam t_value ERROR_RESET = -48'sd99000;

    // Special characters.
    localparam t_char CHAR_NUL   = 8'd0;
    localparam t_char CHAR_SEP   = 8'd38;
    localparam t_char DIGIT_BASE = 8'd48;
    localparam t_char CHAR_X     = 8'd120;
    localparam t_char CHAR_Y     = 8'd121;
    localparam t_char CHAR_F     = 8'd102;
    localparam t_char CHAR_A     = 8'd97;

    // Value slots, one for each known tag.
    localparam t_slot SLOT_XF = 2'd0;
    localparam t_slot SLOT_YF = 2'd1;
    localparam t_slot SLOT_XA = 2'd2;
    localparam t_slot SLOT_YA = 2'd3;

    // One character request as it sits in the input register.
    typedef struct packed {
        t_char char_byte;
        logic  last_of_message;
    } t_char_req;

    // One finished message.
    typedef struct packed {
        t_value_arr values;
        logic       bad_field_seen;
    } t_result;

    // Outcome of a tag lookup.
    typedef struct packed {
        logic  hit;
        t_slot slot;
    } t_tag_match;

    // Map a two-letter tag to its value slot.
    function automatic t_tag_match tag_lookup(input t_char first, input t_char second);
        t_tag_match m;
        m.hit  = 1'b1;
        m.slot = SLOT_XF;
        if (first == CHAR_X && second == CHAR_F) begin
            m.slot = SLOT_XF;
        end else if (first == CHAR_Y && second == CHAR_F) begin
            m.slot = SLOT_YF;
        end else if (first == CHAR_X && second == CHAR_A) begin
            m.slot = SLOT_XA;
        end else if (first == CHAR_Y && second == CHAR_A) begin
            m.slot = SLOT_YA;
        end else begin
            m.hit = 1'b0;
        end
        return m;
    endfunction

endpackage

FILE: sv/tdfp_acc_step.sv
// Saturating decimal accumulator step: acc * 10 + (char - 48), clamped to the value range.
module tdfp_acc_step (
    input  tdfp_pkg::t_value i_acc,
    input  tdfp_pkg::t_char  i_char,
    output tdfp_pkg::t_value o_acc
);

    logic signed [tdfp_pkg::WIDE_W-1:0] w_acc_ext;
    logic signed [tdfp_pkg::WIDE_W-1:0] w_digit;
    logic signed [tdfp_pkg::WIDE_W-1:0] w_sum;
    logic                               w_in_range;

    // Times ten as two shifts, then add the character offset.
    assign w_acc_ext = {{(tdfp_pkg::WIDE_W-tdfp_pkg::VALUE_W){i_acc[tdfp_pkg::VALUE_W-1]}}, i_acc};
    assign w_digit   = $signed({{(tdfp_pkg::WIDE_W-tdfp_pkg::CHAR_W){1'b0}}, i_char})
                     - $signed({{(tdfp_pkg::WIDE_W-tdfp_pkg::CHAR_W){1'b0}}, tdfp_pkg::DIGIT_BASE});
    assign w_sum     = (w_acc_ext <<< 3) + (w_acc_ext <<< 1) + w_digit;

    // The sum fits when all bits above the value's sign bit agree with it.
    assign w_in_range = (&w_sum[tdfp_pkg::WIDE_W-1:tdfp_pkg::VALUE_W-1])
                      | ~(|w_sum[tdfp_pkg::WIDE_W-1:tdfp_pkg::VALUE_W-1]);

    always_comb begin
        if (w_in_range) begin
            o_acc = w_sum[tdfp_pkg::VALUE_W-1:0];
        end else if (w_sum[tdfp_pkg::WIDE_W-1]) begin
            o_acc = tdfp_pkg::VALUE_MIN;
        end else begin
            o_acc = tdfp_pkg::VALUE_MAX;
        end
    end

endmodule

FILE: sv/tdfp_parser.sv
// Message state and field handling: one character is applied per step.
module tdfp_parser #(
    parameter int MAX_CHARS       = 256,
    parameter int MAX_FIELD_CHARS = 50,
    parameter int FIELD_COUNT     = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  tdfp_pkg::t_char_req i_req,
    input  tdfp_pkg::t_value    i_error_value,
    output logic                o_emit,
    output tdfp_pkg::t_result   o_result
);

    localparam int LEN_W = $clog2(MAX_CHARS + 1);
    localparam int CH_W  = $clog2(MAX_FIELD_CHARS + 1);
    localparam int FN_W  = $clog2(FIELD_COUNT + 1);

    localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(MAX_CHARS);
    localparam logic [CH_W-1:0]  CH_LIMIT    = CH_W'(MAX_FIELD_CHARS);
    localparam logic [CH_W-1:0]  CH_TAG_LEN  = CH_W'(2);
    localparam logic [FN_W-1:0]  FN_LIMIT    = FN_W'(FIELD_COUNT);
    localparam logic [FN_W-1:0]  FN_LAST     = FN_W'(FIELD_COUNT - 1);

    logic [FN_W-1:0]      r_field_num, n_field_num;
    tdfp_pkg::t_char      r_tag1, n_tag1;
    tdfp_pkg::t_char      r_tag2, n_tag2;
    logic [CH_W-1:0]      r_chars, n_chars;
    tdfp_pkg::t_value     r_acc, n_acc;
    tdfp_pkg::t_value_arr r_vals, n_vals;
    logic [LEN_W-1:0]     r_msg_len, n_msg_len;
    logic                 r_text_ended, n_text_ended;
    logic                 r_bad, n_bad;

    tdfp_pkg::t_value     w_acc_next;
    tdfp_pkg::t_tag_match w_match;
    logic                 w_active;

    tdfp_acc_step u_acc_step (
        .i_acc  (r_acc),
        .i_char (i_req.char_byte),
        .o_acc  (w_acc_next)
    );

    assign w_active = !r_text_ended && (r_msg_len < LEN_LIMIT) && (r_field_num < FN_LIMIT);
    assign o_emit   = i_step && i_req.last_of_message;

    // Next state: apply the character, then close the message on the last one.
    always_comb begin
        n_field_num  = r_field_num;
        n_tag1       = r_tag1;
        n_tag2       = r_tag2;
        n_chars      = r_chars;
        n_acc        = r_acc;
        n_vals       = r_vals;
        n_msg_len    = r_msg_len;
        n_text_ended = r_text_ended;
        n_bad        = r_bad;
        o_result     = '0;
        w_match      = '0;

        if (i_step) begin
            if (w_active) begin
                n_msg_len = r_msg_len + LEN_W'(1);
                if (i_req.char_byte == tdfp_pkg::CHAR_NUL) begin
                    n_text_ended = 1'b1;
                end else if (i_req.char_byte == tdfp_pkg::CHAR_SEP) begin
                    // A separator closes the current field.
                    w_match = tdfp_pkg::tag_lookup(r_tag1, r_tag2);
                    if (r_chars >= CH_TAG_LEN && w_match.hit) begin
                        n_vals[w_match.slot] = r_acc;
                    end else begin
                        n_vals = {tdfp_pkg::SLOT_COUNT{i_error_value}};
                        n_bad  = 1'b1;
                    end
                    n_tag1      = '0;
                    n_tag2      = '0;
                    n_chars     = '0;
                    n_acc       = '0;
                    n_field_num = r_field_num + FN_W'(1);
                end else if (r_chars < CH_LIMIT) begin
                    if (r_chars == '0) begin
                        n_tag1 = i_req.char_byte;
                    end else if (r_chars == CH_W'(1)) begin
                        n_tag2 = i_req.char_byte;
                    end else begin
                        n_acc = w_acc_next;
                    end
                    n_chars = r_chars + CH_W'(1);
                end
            end

            if (i_req.last_of_message) begin
                // Close the open field and flag fields that never began.
                if (n_field_num < FN_LIMIT) begin
                    w_match = tdfp_pkg::tag_lookup(n_tag1, n_tag2);
                    if (n_chars >= CH_TAG_LEN && w_match.hit) begin
                        n_vals[w_match.slot] = n_acc;
                    end else begin
                        n_vals = {tdfp_pkg::SLOT_COUNT{i_error_value}};
                        n_bad  = 1'b1;
                    end
                    if (n_field_num < FN_LAST) begin
                        n_vals = {tdfp_pkg::SLOT_COUNT{i_error_value}};
                        n_bad  = 1'b1;
                    end
                end
                o_result.values         = n_vals;
                o_result.bad_field_seen = n_bad;

                // Start a fresh message.
                n_field_num  = '0;
                n_tag1       = '0;
                n_tag2       = '0;
                n_chars      = '0;
                n_acc        = '0;
                n_vals       = '0;
                n_msg_len    = '0;
                n_text_ended = 1'b0;
                n_bad        = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_num  <= '0;
            r_tag1       <= '0;
            r_tag2       <= '0;
            r_chars      <= '0;
            r_acc        <= '0;
            r_vals       <= '0;
            r_msg_len    <= '0;
            r_text_ended <= 1'b0;
            r_bad        <= 1'b0;
        end else begin
            r_field_num  <= n_field_num;
            r_tag1       <= n_tag1;
            r_tag2       <= n_tag2;
            r_chars      <= n_chars;
            r_acc        <= n_acc;
            r_vals       <= n_vals;
            r_msg_len    <= n_msg_len;
            r_text_ended <= n_text_ended;
            r_bad        <= n_bad;
        end
    end

    // Counters never run past their limits.
    a_field_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_num <= FN_LIMIT)
        else $error("field number past field count");

    a_chars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chars <= CH_LIMIT) && (r_msg_len <= LEN_LIMIT))
        else $error("character counter past its limit");

    // A finished message leaves the parser ready for a fresh one.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> ((r_field_num == '0) && (r_msg_len == '0) && !r_bad))
        else $error("message state not cleared after a result");

endmodule

FILE: sv/tagged_decimal_field_parser_core.sv
// Top level of the tagged decimal field parser: input register, parser and result register.
//
// Usage: characters of a message enter one per request on the input channel
// (i_char_byte, with i_last_of_message high on the final byte). Fields are
// separated by '&' and each begins with a tag xf, yf, xa or ya followed by
// decimal digits read as thousandths. On the final byte one result leaves on
// the output channel: the four values and the bad-field flag.
// The error value register is written through the configuration channel,
// which is always ready; write it only while no message is in progress.
// A result is valid once its last byte has passed the input register and the
// result register has loaded. Throughput: one byte per cycle, set by the
// combinational multiply-add and field update between the input register and
// the state registers, except while a final byte waits as described below.
// When the receiver stalls, the result register holds its result; bytes that
// do not end a message keep flowing, and a final byte waits in the input
// register until the result register frees.
// Reset clears all message state and loads the error value -99.000
// (-99000 thousandths); no output is valid until a message ends.
module tagged_decimal_field_parser_core #(
    parameter int MAX_CHARS       = 256,
    parameter int MAX_FIELD_CHARS = 50,
    parameter int FIELD_COUNT     = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic signed [47:0]         i_error_value,
    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_char_byte,
    input  logic                       i_last_of_message,
    // Output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [47:0]         o_x_primary_value,
    output logic signed [47:0]         o_y_primary_value,
    output logic signed [47:0]         o_x_secondary_value,
    output logic signed [47:0]         o_y_secondary_value,
    output logic                       o_bad_field_seen
);

    tdfp_pkg::t_value    r_error_value;
    logic                r_in_valid;
    tdfp_pkg::t_char_req r_in_req;
    logic                r_out_valid;
    tdfp_pkg::t_result   r_out;

    logic                w_step;
    logic                w_emit;
    tdfp_pkg::t_result   w_result;

    // A buffered byte moves on unless it ends a message and the result slot is full and not being drained.
    assign w_step      = r_in_valid && (!r_in_req.last_of_message || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    // Error value register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_value <= tdfp_pkg::ERROR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_error_value <= i_error_value;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_req.char_byte       <= i_char_byte;
            r_in_req.last_of_message <= i_last_of_message;
        end
    end

    tdfp_parser #(
        .MAX_CHARS       (MAX_CHARS),
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
        .FIELD_COUNT     (FIELD_COUNT)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_req         (r_in_req),
        .i_error_value (r_error_value),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_x_primary_value   = $signed(r_out.values[tdfp_pkg::SLOT_XF]);
    assign o_y_primary_value   = $signed(r_out.values[tdfp_pkg::SLOT_YF]);
    assign o_x_secondary_value = $signed(r_out.values[tdfp_pkg::SLOT_XA]);
    assign o_y_secondary_value = $signed(r_out.values[tdfp_pkg::SLOT_YA]);
    assign o_bad_field_seen    = r_out.bad_field_seen;

    // A byte that does not end a message never blocks the input.
    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_req.last_of_message) |-> o_in_ready)
        else $error("mid-message byte stalled the input");

    // A finished message is presented in the next cycle.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out_valid)
        else $error("result not presented after the last byte");

    // A result is only produced when the slot is free or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_out_valid) |-> i_out_ready)
        else $error("result register overwritten while stalled");

endmodule

FILE: dv/tagged_decimal_field_parser_core_tb.sv
// Self-checking testbench for the tagged decimal field parser core with its own parser model.
`timescale 1ns / 100ps

module tagged_decimal_field_parser_core_tb;

    localparam int MSG_CHARS    = 256;
    localparam int FIELD_CHARS  = 50;
    localparam int FIELDS       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {MSG_WELL, MSG_BROKEN, MSG_NOISE, MSG_LONG_TEXT} t_msg_kind;
    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic             clk             = 1'b0;
    logic             rst_n           = 1'b0;
    logic             cfg_valid       = 1'b0;
    logic             cfg_ready;
    tdfp_pkg::t_value cfg_error_value = '0;
    logic             in_valid        = 1'b0;
    logic             in_ready;
    tdfp_pkg::t_char  in_char         = '0;
    logic             in_last         = 1'b0;
    logic             out_valid;
    logic             out_ready       = 1'b1;
    tdfp_pkg::t_value x_primary;
    tdfp_pkg::t_value y_primary;
    tdfp_pkg::t_value x_secondary;
    tdfp_pkg::t_value y_secondary;
    logic             bad_field;

    // Pending character requests, the message under construction and the predicted results.
    tdfp_pkg::t_char_req char_stream[$];
    tdfp_pkg::t_char     msg_bytes[$];
    tdfp_pkg::t_result   predicted_values[$];
    int                  queued_chars   = 0;
    int                  accepted_chars = 0;
    int                  mismatches     = 0;
    int                  cycles         = 0;

    // Sender burst shaping and receiver stall pattern.
    int       burst_left = 0;
    int       gap_left   = 0;
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_span    = 0;

    // Parser model state.
    tdfp_pkg::t_value err_fill;
    logic [2:0]       field_idx;
    tdfp_pkg::t_char  tag_first;
    tdfp_pkg::t_char  tag_second;
    logic [5:0]       field_len;
    tdfp_pkg::t_value digit_sum;
    tdfp_pkg::t_value slot_val[tdfp_pkg::SLOT_COUNT];
    logic [8:0]       text_len;
    logic             text_stop;
    logic             bad_seen;

    tagged_decimal_field_parser_core #(
        .MAX_CHARS      (MSG_CHARS),
        .MAX_FIELD_CHARS(FIELD_CHARS),
        .FIELD_COUNT    (FIELDS)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_error_value      (cfg_error_value),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_char_byte        (in_char),
        .i_last_of_message  (in_last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_x_primary_value  (x_primary),
        .o_y_primary_value  (y_primary),
        .o_x_secondary_value(x_secondary),
        .o_y_secondary_value(y_secondary),
        .o_bad_field_seen   (bad_field)
    );

    // A bad field loads the error value into every slot.
    function automatic void flag_all_bad();
        for (int k = 0; k < tdfp_pkg::SLOT_COUNT; k++) begin
            slot_val[k] = err_fill;
        end
        bad_seen = 1'b1;
    endfunction

    // Put the field in its tag's slot, or flag all bad if its tag is unknown; then clear it.
    function automatic void close_field();
        int slot;
        slot = -1;
        if (field_len >= 2) begin
            case ({tag_first, tag_second})
                {tdfp_pkg::CHAR_X, tdfp_pkg::CHAR_F}: slot = tdfp_pkg::SLOT_XF;
                {tdfp_pkg::CHAR_Y, tdfp_pkg::CHAR_F}: slot = tdfp_pkg::SLOT_YF;
                {tdfp_pkg::CHAR_X, tdfp_pkg::CHAR_A}: slot = tdfp_pkg::SLOT_XA;
                {tdfp_pkg::CHAR_Y, tdfp_pkg::CHAR_A}: slot = tdfp_pkg::SLOT_YA;
                default:                              slot = -1;
            endcase
        end
        if (slot < 0) begin
            flag_all_bad();
        end else begin
            slot_val[slot] = digit_sum;
        end
        tag_first  = '0;
        tag_second = '0;
        field_len  = '0;
        digit_sum  = '0;
    endfunction

    function automatic void clear_message();
        field_idx = '0;
        close_field();
        for (int k = 0; k < tdfp_pkg::SLOT_COUNT; k++) begin
            slot_val[k] = '0;
        end
        text_len  = '0;
        text_stop = 1'b0;
        bad_seen  = 1'b0;
    endfunction

    function automatic void reset_parser();
        err_fill = tdfp_pkg::ERROR_RESET;
        clear_message();
    endfunction

    // Advance the parser by one character and predict the result when the message ends.
    function automatic void parse_char(input tdfp_pkg::t_char c, input logic last);
        longint            sum;
        tdfp_pkg::t_result r;
        if (!text_stop && text_len < MSG_CHARS && field_idx < FIELDS) begin
            text_len++;
            if (c == tdfp_pkg::CHAR_NUL) begin
                text_stop = 1'b1;
            end else if (c == tdfp_pkg::CHAR_SEP) begin
                close_field();
                field_idx++;
            end else if (field_len < FIELD_CHARS) begin
                if (field_len == 0) begin
                    tag_first = c;
                end else if (field_len == 1) begin
                    tag_second = c;
                end else begin
                    // Any byte after the tag counts as a digit, with saturation.
                    sum = longint'(digit_sum) * 10 + longint'(c)
                        - longint'(tdfp_pkg::DIGIT_BASE);
                    if (sum > longint'(tdfp_pkg::VALUE_MAX)) begin
                        sum = longint'(tdfp_pkg::VALUE_MAX);
                    end
                    if (sum < longint'(tdfp_pkg::VALUE_MIN)) begin
                        sum = longint'(tdfp_pkg::VALUE_MIN);
                    end
                    digit_sum = tdfp_pkg::t_value'(sum);
                end
                field_len++;
            end
        end
        if (last) begin
            // A message that stops before its last field has begun is bad.
            if (field_idx < FIELDS) begin
                close_field();
                if (field_idx + 1 < FIELDS) begin
                    flag_all_bad();
                end
            end
            for (int k = 0; k < tdfp_pkg::SLOT_COUNT; k++) begin
                r.values[k] = slot_val[k];
            end
            r.bad_field_seen = bad_seen;
            predicted_values.push_back(r);
            clear_message();
        end
    endfunction

    function automatic void check_value(input string name, input tdfp_pkg::t_value want,
                                        input tdfp_pkg::t_value got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Any byte except the separator and NUL.
    function automatic tdfp_pkg::t_char odd_byte();
        tdfp_pkg::t_char c;
        do begin
            c = tdfp_pkg::t_char'($urandom_range(1, 255));
        end while (c == tdfp_pkg::CHAR_SEP);
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            msg_bytes.push_back(tdfp_pkg::t_char'(s[i]));
        end
    endtask

    task automatic add_digits(input int n);
        repeat (n) begin
            if ($urandom_range(0, 29) == 0) begin
                msg_bytes.push_back(odd_byte());
            end else begin
                msg_bytes.push_back(tdfp_pkg::t_char'(tdfp_pkg::DIGIT_BASE
                                                      + $urandom_range(0, 9)));
            end
        end
    endtask

    // Move the built message into the request queue, marking its final byte.
    task automatic flush_message();
        tdfp_pkg::t_char_req req;
        foreach (msg_bytes[i]) begin
            req.char_byte       = msg_bytes[i];
            req.last_of_message = (i == msg_bytes.size() - 1);
            char_stream.push_back(req);
        end
        queued_chars += msg_bytes.size();
        msg_bytes.delete();
    endtask

    task automatic queue_message(input t_msg_kind kind);
        int n_fields;
        int r;
        int span;
        case (kind)
            MSG_WELL: begin
                // Mostly four fields; sometimes too few or too many.
                n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : FIELDS;
                for (int f = 0; f < n_fields; f++) begin
                    if (f > 0) begin
                        msg_bytes.push_back(tdfp_pkg::CHAR_SEP);
                    end
                    r = $urandom_range(0, 99);
                    if (r >= 3) begin
                        if (r < 88) begin
                            msg_bytes.push_back($urandom_range(0, 1) ?
                                tdfp_pkg::CHAR_Y : tdfp_pkg::CHAR_X);
                            msg_bytes.push_back($urandom_range(0, 1) ?
                                tdfp_pkg::CHAR_A : tdfp_pkg::CHAR_F);
                        end else begin
                            msg_bytes.push_back(odd_byte());
                            msg_bytes.push_back(odd_byte());
                        end
                        span = $urandom_range(0, 99);
                        if (span < 5) begin
                            // A run of nines saturates; a low first byte drives it negative.
                            msg_bytes.push_back($urandom_range(0, 1) ?
                                tdfp_pkg::t_char'(tdfp_pkg::DIGIT_BASE + 9) :
                                tdfp_pkg::t_char'($urandom_range(1, 37)));
                            repeat ($urandom_range(15, 20)) begin
                                msg_bytes.push_back(tdfp_pkg::t_char'(tdfp_pkg::DIGIT_BASE + 9));
                            end
                        end else if (span < 8) begin
                            add_digits($urandom_range(46, 60));
                        end else begin
                            add_digits($urandom_range(0, 7));
                        end
                    end
                end
                // Occasionally a NUL cuts the text short.
                if ($urandom_range(0, 19) == 0) begin
                    if (msg_bytes.size() == 0) begin
                        msg_bytes.push_back(tdfp_pkg::CHAR_NUL);
                    end else begin
                        msg_bytes.insert($urandom_range(0, msg_bytes.size() - 1),
                                         tdfp_pkg::CHAR_NUL);
                    end
                    add_digits($urandom_range(1, 3));
                end
            end
            MSG_BROKEN: begin
                repeat ($urandom_range(1, 10)) begin
                    case ($urandom_range(0, 5))
                        0:       msg_bytes.push_back(tdfp_pkg::CHAR_X);
                        1:       msg_bytes.push_back(tdfp_pkg::CHAR_Y);
                        2:       msg_bytes.push_back(tdfp_pkg::CHAR_F);
                        3:       msg_bytes.push_back(tdfp_pkg::CHAR_A);
                        4:       msg_bytes.push_back(tdfp_pkg::CHAR_SEP);
                        default: msg_bytes.push_back(tdfp_pkg::t_char'(tdfp_pkg::DIGIT_BASE
                                                     + $urandom_range(0, 9)));
                    endcase
                end
            end
            MSG_NOISE: begin
                repeat ($urandom_range(1, 8)) begin
                    msg_bytes.push_back(tdfp_pkg::t_char'($urandom_range(0, 255)));
                end
            end
            default: begin
                // Overruns the character limit; the tail is ignored but still ends the message.
                msg_bytes.push_back(tdfp_pkg::CHAR_X);
                msg_bytes.push_back(tdfp_pkg::CHAR_A);
                add_digits(260);
                add_text("&yf1");
            end
        endcase
        flush_message();
    endtask

    // Idle means every queued request accepted and every predicted result received.
    task automatic wait_idle();
        @(posedge clk);
        while (accepted_chars != queued_chars || predicted_values.size() != 0) begin
            @(posedge clk);
        end
    endtask

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop if the run hangs.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Request driver: bursts of characters with random gaps in between.
    always @(posedge clk) begin : char_driver
        tdfp_pkg::t_char_req req;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            reset_parser();
        end else begin
            // Predict the response to a request accepted at this edge.
            if (in_valid && in_ready) begin
                parse_char(in_char, in_last);
                accepted_chars++;
            end
            // Offer the next request unless the current one is still waiting.
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (char_stream.size() != 0) begin
                    req = char_stream.pop_front();
                    in_char  <= req.char_byte;
                    in_last  <= req.last_of_message;
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ?
                            $urandom_range(40, 120) : $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stalls: modes of random length, from always ready to mostly stalled.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b1;
            rx_mode = RX_OPEN;
            rx_span = 0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_span = $urandom_range(16, 160);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (rx_span % 6 != 0);
            endcase
        end
    end

    // Result monitor: each accepted result is checked against the oldest prediction.
    always @(posedge clk) begin : result_check
        tdfp_pkg::t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (predicted_values.size() == 0) begin
                $error("result with no expectation waiting");
                mismatches++;
            end else begin
                want = predicted_values.pop_front();
                check_value("x_primary_value",
                            tdfp_pkg::t_value'(want.values[tdfp_pkg::SLOT_XF]), x_primary);
                check_value("y_primary_value",
                            tdfp_pkg::t_value'(want.values[tdfp_pkg::SLOT_YF]), y_primary);
                check_value("x_secondary_value",
                            tdfp_pkg::t_value'(want.values[tdfp_pkg::SLOT_XA]), x_secondary);
                check_value("y_secondary_value",
                            tdfp_pkg::t_value'(want.values[tdfp_pkg::SLOT_YA]), y_secondary);
                check_value("bad_field_seen", tdfp_pkg::t_value'(want.bad_field_seen),
                            tdfp_pkg::t_value'(bad_field));
            end
        end
    end

    initial begin : stimulus
        tdfp_pkg::t_value err_setting;
        t_msg_kind        kind;
        int               r;
        int               phase_start;
        int               phase_msgs;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages: all four tags with a tag-only field, an unknown tag with
        // missing fields, a lone NUL, and empty fields with a byte past the last separator.
        add_text("xf5&yf&xa7&ya8");
        flush_message();
        msg_bytes.push_back(8'hFF);
        add_text("z");
        flush_message();
        msg_bytes.push_back(tdfp_pkg::CHAR_NUL);
        flush_message();
        add_text("&&&&x");
        flush_message();

        for (int phase = 0; phase < 6; phase++) begin
            // Change the error value only once the parser has drained.
            if (phase > 0) begin
                wait_idle();
                repeat (4) @(posedge clk);
                case (phase)
                    1:       err_setting = tdfp_pkg::VALUE_MAX;
                    2:       err_setting = tdfp_pkg::VALUE_MIN;
                    3:       err_setting = '0;
                    4:       err_setting = tdfp_pkg::t_value'({$urandom(), $urandom()});
                    default: err_setting = tdfp_pkg::ERROR_RESET;
                endcase
                cfg_error_value <= err_setting;
                cfg_valid       <= 1'b1;
                @(posedge clk);
                while (!cfg_ready) begin
                    @(posedge clk);
                end
                err_fill = err_setting;
                cfg_valid <= 1'b0;
            end

            phase_start = queued_chars;
            phase_msgs  = 0;
            if (phase == 1) begin
                queue_message(MSG_LONG_TEXT);
            end
            while (queued_chars - phase_start < 40 || phase_msgs < 3) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    kind = MSG_WELL;
                end else if (r < 85) begin
                    kind = MSG_BROKEN;
                end else begin
                    kind = MSG_NOISE;
                end
                queue_message(kind);
                phase_msgs++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
